### design/afpm_pkg.sv
// Shared types, constants and register map for the authority fault policy monitor.
package afpm_pkg;

  localparam int MAX_ROTORS = 16;
  localparam int TIMER_BITS = 16;

  localparam int HC_W    = 5;
  localparam int AUTH_W  = 16;
  localparam int DELTA_W = 8;
  localparam int TICK_W  = 16;
  localparam int MODE_W  = 2;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_MODE           = 3'd0,
    REG_MIN_HEALTHY    = 3'd1,
    REG_MIN_COLLECTIVE = 3'd2,
    REG_MIN_ROLL       = 3'd3,
    REG_MIN_PITCH      = 3'd4,
    REG_MIN_YAW        = 3'd5,
    REG_CONFIRM_TICKS  = 3'd6,
    REG_RECOVERY_TICKS = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HC_W-1:0]   min_healthy_rotors;
    logic [AUTH_W-1:0] min_collective;
    logic [AUTH_W-1:0] min_roll;
    logic [AUTH_W-1:0] min_pitch;
    logic [AUTH_W-1:0] min_yaw;
    logic [TICK_W-1:0] confirm_ticks;
    logic [TICK_W-1:0] recovery_ticks;
  } cfg_t;

  typedef struct packed {
    logic               sample_valid;
    logic [DELTA_W-1:0] delta_ticks;
    logic [HC_W-1:0]    healthy_count;
    logic [AUTH_W-1:0]  collective_auth;
    logic [AUTH_W-1:0]  roll_auth;
    logic [AUTH_W-1:0]  pitch_auth;
    logic [AUTH_W-1:0]  yaw_auth;
  } sample_t;

  typedef struct packed {
    logic yaw_violation;
    logic pitch_violation;
    logic roll_violation;
    logic collective_violation;
    logic count_violation;
    logic violation_any;
    logic latched;
    logic fire;
  } result_t;

endpackage

### design/afpm_apb_regs.sv
// APB register file holding the monitor's configuration.
module afpm_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [afpm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [afpm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [afpm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output afpm_pkg::cfg_t                   cfg
);

  logic                 wr_en;
  afpm_pkg::reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = afpm_pkg::reg_index_t'(paddr[afpm_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        afpm_pkg::REG_MODE:
          cfg.mode <= pwdata[afpm_pkg::MODE_W-1:0];
        afpm_pkg::REG_MIN_HEALTHY:
          cfg.min_healthy_rotors <= pwdata[afpm_pkg::HC_W-1:0];
        afpm_pkg::REG_MIN_COLLECTIVE:
          cfg.min_collective <= pwdata[afpm_pkg::AUTH_W-1:0];
        afpm_pkg::REG_MIN_ROLL:
          cfg.min_roll <= pwdata[afpm_pkg::AUTH_W-1:0];
        afpm_pkg::REG_MIN_PITCH:
          cfg.min_pitch <= pwdata[afpm_pkg::AUTH_W-1:0];
        afpm_pkg::REG_MIN_YAW:
          cfg.min_yaw <= pwdata[afpm_pkg::AUTH_W-1:0];
        afpm_pkg::REG_CONFIRM_TICKS:
          cfg.confirm_ticks <= pwdata[afpm_pkg::TICK_W-1:0];
        afpm_pkg::REG_RECOVERY_TICKS:
          cfg.recovery_ticks <= pwdata[afpm_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      afpm_pkg::REG_MODE:
        prdata = afpm_pkg::APB_DATA_W'(cfg.mode);
      afpm_pkg::REG_MIN_HEALTHY:
        prdata = afpm_pkg::APB_DATA_W'(cfg.min_healthy_rotors);
      afpm_pkg::REG_MIN_COLLECTIVE:
        prdata = afpm_pkg::APB_DATA_W'(cfg.min_collective);
      afpm_pkg::REG_MIN_ROLL:
        prdata = afpm_pkg::APB_DATA_W'(cfg.min_roll);
      afpm_pkg::REG_MIN_PITCH:
        prdata = afpm_pkg::APB_DATA_W'(cfg.min_pitch);
      afpm_pkg::REG_MIN_YAW:
        prdata = afpm_pkg::APB_DATA_W'(cfg.min_yaw);
      afpm_pkg::REG_CONFIRM_TICKS:
        prdata = afpm_pkg::APB_DATA_W'(cfg.confirm_ticks);
      afpm_pkg::REG_RECOVERY_TICKS:
        prdata = afpm_pkg::APB_DATA_W'(cfg.recovery_ticks);
      default: prdata = '0;
    endcase
  end

endmodule

### design/afpm_policy.sv
// Violation checks, confirm and recovery timers, and the trigger latch.
module afpm_policy (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  afpm_pkg::cfg_t     cfg,
  input  afpm_pkg::sample_t  sample,
  output afpm_pkg::result_t  result
);

  localparam int TB  = afpm_pkg::TIMER_BITS;
  localparam int CMP_W = (TB > afpm_pkg::TICK_W) ? TB : afpm_pkg::TICK_W;

  logic          trigger_latch, trigger_latch_next;
  logic [TB-1:0] violation_timer, violation_timer_next;
  logic [TB-1:0] recovery_timer, recovery_timer_next;
  logic [5:0]    violation_flags, violation_flags_next;

  logic [afpm_pkg::HC_W-1:0] healthy_sat;
  logic [5:0]                flags_now;
  logic [TB:0]               vt_sum, rt_sum;
  logic [TB-1:0]             vt_sat, rt_sat;
  logic                      enabled, fire;

  assign enabled = (cfg.mode != '0) && sample.sample_valid;

  always_comb begin
    if (int'(sample.healthy_count) > afpm_pkg::MAX_ROTORS) begin
      healthy_sat = afpm_pkg::HC_W'(afpm_pkg::MAX_ROTORS);
    end else begin
      healthy_sat = sample.healthy_count;
    end
  end

  // Zero minimum disables its check.
  always_comb begin
    flags_now[1] = (cfg.min_healthy_rotors != '0) && (healthy_sat < cfg.min_healthy_rotors);
    flags_now[2] = (cfg.min_collective != '0) && (sample.collective_auth < cfg.min_collective);
    flags_now[3] = (cfg.min_roll != '0) && (sample.roll_auth < cfg.min_roll);
    flags_now[4] = (cfg.min_pitch != '0) && (sample.pitch_auth < cfg.min_pitch);
    flags_now[5] = (cfg.min_yaw != '0) && (sample.yaw_auth < cfg.min_yaw);
    flags_now[0] = |flags_now[5:1];
  end

  // Saturating timer adds.
  assign vt_sum = {1'b0, violation_timer} + (TB+1)'(sample.delta_ticks);
  assign rt_sum = {1'b0, recovery_timer} + (TB+1)'(sample.delta_ticks);
  assign vt_sat = vt_sum[TB] ? '1 : vt_sum[TB-1:0];
  assign rt_sat = rt_sum[TB] ? '1 : rt_sum[TB-1:0];

  always_comb begin
    trigger_latch_next   = trigger_latch;
    violation_timer_next = violation_timer;
    recovery_timer_next  = recovery_timer;
    violation_flags_next = violation_flags;
    fire                 = 1'b0;
    if (enabled) begin
      violation_flags_next = flags_now;
      if (flags_now[0]) begin
        recovery_timer_next = '0;
        if (!trigger_latch) begin
          violation_timer_next = vt_sat;
          if (CMP_W'(vt_sat) >= CMP_W'(cfg.confirm_ticks)) begin
            trigger_latch_next = 1'b1;
            fire               = 1'b1;
          end
        end
      end else begin
        violation_timer_next = '0;
        if (trigger_latch && !cfg.mode[1]) begin
          recovery_timer_next = rt_sat;
          if (CMP_W'(rt_sat) >= CMP_W'(cfg.recovery_ticks)) begin
            trigger_latch_next   = 1'b0;
            violation_timer_next = '0;
            recovery_timer_next  = '0;
            violation_flags_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_latch   <= 1'b0;
      violation_timer <= '0;
      recovery_timer  <= '0;
      violation_flags <= '0;
    end else if (advance) begin
      trigger_latch   <= trigger_latch_next;
      violation_timer <= violation_timer_next;
      recovery_timer  <= recovery_timer_next;
      violation_flags <= violation_flags_next;
    end
  end

  always_comb begin
    result.fire                 = fire;
    result.latched              = trigger_latch_next;
    result.violation_any        = violation_flags_next[0];
    result.count_violation      = violation_flags_next[1];
    result.collective_violation = violation_flags_next[2];
    result.roll_violation       = violation_flags_next[3];
    result.pitch_violation      = violation_flags_next[4];
    result.yaw_violation        = violation_flags_next[5];
  end

endmodule

### design/authority_fault_policy_monitor.sv
// Top level of the authority fault policy monitor: stream ports, input and result registers.
//
// Takes one tick sample per beat and returns exactly one result beat per
// sample. A sample is held in the input register, the checks, timer
// updates and latch update run in a single pass of logic, and the result
// lands in the result register; one sample can be taken every cycle,
// limited only by back-pressure on the result side. Each non-zero minimum
// is compared with its sample (healthy count saturated to the rotor limit
// first); any violation accumulates a saturating tick timer that fires once
// and sets the latch when it reaches confirm_ticks. In auto recovery mode a
// clean run of recovery_ticks clears the latch, both timers and all flags.
// With mode 0 or sample_valid low the state holds and fire stays low. Write
// the configuration registers only while no sample is in flight.
module authority_fault_policy_monitor (
  input  logic                             clk,
  input  logic                             rst,
  // stream in
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] delta_ticks, [12:8] healthy_count, [28:13] collective_auth,
  // [44:29] roll_auth, [60:45] pitch_auth, [76:61] yaw_auth, [79:77] zero
  input  logic [afpm_pkg::IN_DATA_W-1:0]   s_tdata,
  // [0] sample_valid
  input  logic                             s_tuser,
  // stream out
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] fire, [1] latched, [2] violation_any, [3] count_violation,
  // [4] collective_violation, [5] roll_violation, [6] pitch_violation,
  // [7] yaw_violation
  output logic [afpm_pkg::OUT_DATA_W-1:0]  m_tdata,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [afpm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [afpm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [afpm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  afpm_pkg::cfg_t    cfg;
  afpm_pkg::sample_t in_item, in_reg;
  afpm_pkg::result_t result;
  afpm_pkg::result_t out_reg;
  logic              in_full;
  logic              out_free;
  logic              advance;

  afpm_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Unpack the input beat.
  always_comb begin
    in_item.sample_valid    = s_tuser;
    in_item.delta_ticks     = s_tdata[7:0];
    in_item.healthy_count   = s_tdata[12:8];
    in_item.collective_auth = s_tdata[28:13];
    in_item.roll_auth       = s_tdata[44:29];
    in_item.pitch_auth      = s_tdata[60:45];
    in_item.yaw_auth        = s_tdata[76:61];
  end

  // Advance the held sample when the result register is empty or draining.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_full && out_free;
  assign s_tready = !in_full || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_reg <= in_item;
    end
  end

  afpm_policy u_policy (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .sample  (in_reg),
    .result  (result)
  );

  // Result register: load on advance, drop valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign m_tdata = out_reg;

endmodule
